>>> rtl/lrc_pkg.sv
// Shared types and codes for the link restart controller.
package lrc_pkg;

  localparam int unsigned HANDLE_W = 8;
  localparam int unsigned TIMER_W  = 16;
  localparam int unsigned TYPE_W   = 3;
  localparam int unsigned ACT_W    = 3;
  localparam logic [TIMER_W-1:0] T0_RELOAD_RST = 16'd1800;

  // input request types
  localparam logic [TYPE_W-1:0] REQ_TICK    = 3'd0;
  localparam logic [TYPE_W-1:0] REQ_TX      = 3'd1;
  localparam logic [TYPE_W-1:0] REQ_RX_REQ  = 3'd2;
  localparam logic [TYPE_W-1:0] REQ_RX_CONF = 3'd3;

  // result actions
  localparam logic [ACT_W-1:0] ACT_NONE      = 3'd0;
  localparam logic [ACT_W-1:0] ACT_SEND_DATA = 3'd1;
  localparam logic [ACT_W-1:0] ACT_SEND_REQ  = 3'd2;
  localparam logic [ACT_W-1:0] ACT_SEND_CONF = 3'd3;
  localparam logic [ACT_W-1:0] ACT_QUEUED    = 3'd4;
  localparam logic [ACT_W-1:0] ACT_DROPPED   = 3'd5;

  // configuration register indexes
  localparam logic REG_T0_RELOAD = 1'b0;

  typedef enum logic [2:0] {
    CMD_TICK,
    CMD_TX,
    CMD_RX_REQ,
    CMD_RX_CONF,
    CMD_RX_OTHER
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t           kind;
    logic [HANDLE_W-1:0] handle;
    logic                link_up;
  } cmd_t;

  // handshake between command queue and back end
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } cmd_req_t;

endpackage

>>> rtl/link_restart_controller_top.sv
// Link restart controller: APB register, command front end, queue and back end.
// First result of a request passes the queue register and then the result register,
//   and also S_FLUSH when a received frame starts a flush without a confirmation.
// Throughput: one command per cycle in the back end while the output is free and no
//   extra result waits; a flush sends one held handle per cycle while output is free.
// Reset (rst_n, synchronous): flag, T0 timer, queue pointers and count cleared,
//   t0_reload back to 1800; held frame memory is not cleared.
module link_restart_controller_top #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [7:0] frame_handle, [8] link_up
  input  logic [2:0]  in_tuser,   // [2:0] req_type
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [7:0] out_handle
  output logic [2:0]  out_tuser,  // [2:0] action
  output logic        out_tlast,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic [lrc_pkg::TIMER_W-1:0] t0_reload_r;
  logic                        q_full, q_push, q_pop;
  lrc_pkg::cmd_t               q_cmd;
  lrc_pkg::cmd_req_t           q_head;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == lrc_pkg::REG_T0_RELOAD)
                      ? {16'd0, t0_reload_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t0_reload_r <= lrc_pkg::T0_RELOAD_RST;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                 (cfg_paddr[2] == lrc_pkg::REG_T0_RELOAD)) begin
      t0_reload_r <= cfg_pwdata[15:0];
    end
  end

  lrc_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_cmd     (q_cmd)
  );

  lrc_cmd_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .head     (q_head)
  );

  lrc_back #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .t0_reload  (t0_reload_r),
    .cmd_in     (q_head),
    .cmd_pop    (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_handle (out_tdata),
    .out_action (out_tuser),
    .out_last   (out_tlast)
  );

endmodule

>>> rtl/lrc_front.sv
// Front end: accepts input requests and classifies them into commands.
module lrc_front (
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [15:0]                in_tdata,  // [7:0] frame_handle, [8] link_up
  input  logic [lrc_pkg::TYPE_W-1:0] in_tuser,  // [2:0] req_type
  input  logic                       q_full,
  output logic                       q_push,
  output lrc_pkg::cmd_t              q_cmd
);

  lrc_pkg::cmd_kind_t kind;

  always_comb begin
    case (in_tuser)
      lrc_pkg::REQ_TICK:    kind = lrc_pkg::CMD_TICK;
      lrc_pkg::REQ_TX:      kind = lrc_pkg::CMD_TX;
      lrc_pkg::REQ_RX_REQ:  kind = lrc_pkg::CMD_RX_REQ;
      lrc_pkg::REQ_RX_CONF: kind = lrc_pkg::CMD_RX_CONF;
      default:              kind = lrc_pkg::CMD_RX_OTHER;  // diag, unknown, reserved
    endcase
  end

  assign in_tready      = !q_full;
  assign q_push         = in_tvalid && !q_full;
  assign q_cmd.kind     = kind;
  assign q_cmd.handle   = in_tdata[7:0];
  assign q_cmd.link_up  = in_tdata[8];

endmodule

>>> rtl/lrc_cmd_fifo.sv
// Two-entry command queue between front and back end.
module lrc_cmd_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  lrc_pkg::cmd_t     push_cmd,
  output logic              full,
  input  logic              pop,
  output lrc_pkg::cmd_req_t head
);

  lrc_pkg::cmd_t slot_r [2];
  lrc_pkg::cmd_t slot_nxt [2];
  logic [1:0]    cnt_r, cnt_nxt;

  assign full       = (cnt_r == 2'd2);
  assign head.valid = (cnt_r != 2'd0);
  assign head.cmd   = slot_r[0];

  always_comb begin
    slot_nxt[0] = slot_r[0];
    slot_nxt[1] = slot_r[1];
    cnt_nxt     = cnt_r;
    if (pop && head.valid) begin
      slot_nxt[0] = slot_r[1];
      cnt_nxt     = cnt_nxt - 2'd1;
    end
    if (push) begin
      if (cnt_nxt == 2'd0) begin
        slot_nxt[0] = push_cmd;
      end else begin
        slot_nxt[1] = push_cmd;
      end
      cnt_nxt = cnt_nxt + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    slot_r[0] <= slot_nxt[0];
    slot_r[1] <= slot_nxt[1];
  end

endmodule

>>> rtl/lrc_back.sv
// Back end: restart state, T0 countdown, held frame queue and result register.
module lrc_back #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [lrc_pkg::TIMER_W-1:0]  t0_reload,
  input  lrc_pkg::cmd_req_t            cmd_in,
  output logic                         cmd_pop,
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [lrc_pkg::HANDLE_W-1:0] out_handle,
  output logic [lrc_pkg::ACT_W-1:0]    out_action,
  output logic                         out_last
);

  localparam int unsigned IDX_W = (QUEUE_DEPTH > 2) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

  typedef enum logic [1:0] {S_IDLE, S_REQ, S_FLUSH} state_t;

  state_t                       state_r, state_nxt;
  logic                         restarted_r, restarted_nxt;
  logic [lrc_pkg::TIMER_W-1:0]  cd_r, cd_nxt;
  logic [IDX_W-1:0]             head_r, head_nxt, tail_r, tail_nxt;
  logic [CNT_W-1:0]             count_r, count_nxt;
  logic [lrc_pkg::HANDLE_W-1:0] mem [QUEUE_DEPTH];
  logic [lrc_pkg::HANDLE_W-1:0] rd_data_r;
  logic                         wr_en;

  logic                         out_valid_r, out_valid_nxt;
  logic [lrc_pkg::ACT_W-1:0]    out_action_r, out_action_nxt;
  logic [lrc_pkg::HANDLE_W-1:0] out_handle_r, out_handle_nxt;
  logic                         out_last_r, out_last_nxt;

  logic                         out_free;
  logic                         emit;
  logic [lrc_pkg::ACT_W-1:0]    e_action;
  logic [lrc_pkg::HANDLE_W-1:0] e_handle;
  logic                         e_last;

  assign out_free   = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;
  assign out_action = out_action_r;
  assign out_handle = out_handle_r;
  assign out_last   = out_last_r;

  always_comb begin
    state_nxt     = state_r;
    restarted_nxt = restarted_r;
    cd_nxt        = cd_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    count_nxt     = count_r;
    cmd_pop       = 1'b0;
    wr_en         = 1'b0;
    emit          = 1'b0;
    e_action      = lrc_pkg::ACT_NONE;
    e_handle      = '0;
    e_last        = 1'b1;

    case (state_r)
      S_IDLE: begin
        if (cmd_in.valid && out_free) begin
          cmd_pop = 1'b1;
          case (cmd_in.cmd.kind)
            lrc_pkg::CMD_TICK: begin
              if (cd_r != '0) begin
                cd_nxt = cd_r - 1'b1;
                if (cd_r == lrc_pkg::TIMER_W'(1)) begin
                  emit     = 1'b1;
                  e_action = lrc_pkg::ACT_SEND_REQ;
                  cd_nxt   = t0_reload;
                end
              end
            end
            lrc_pkg::CMD_TX: begin
              if (restarted_r && cmd_in.cmd.link_up) begin
                emit     = 1'b1;
                e_action = lrc_pkg::ACT_SEND_DATA;
                e_handle = cmd_in.cmd.handle;
              end else begin
                restarted_nxt = 1'b0;
                emit          = 1'b1;
                e_handle      = cmd_in.cmd.handle;
                e_last        = (cd_r != '0);
                if (count_r == CNT_FULL) begin
                  e_action = lrc_pkg::ACT_DROPPED;
                end else begin
                  e_action  = lrc_pkg::ACT_QUEUED;
                  wr_en     = 1'b1;
                  tail_nxt  = (tail_r == IDX_LAST) ? '0 : tail_r + 1'b1;
                  count_nxt = count_r + 1'b1;
                end
                // idle timer: the restart request follows as a second result
                if (cd_r == '0) begin
                  cd_nxt    = t0_reload;
                  state_nxt = S_REQ;
                end
              end
            end
            lrc_pkg::CMD_RX_REQ, lrc_pkg::CMD_RX_CONF: begin
              cd_nxt        = '0;
              restarted_nxt = 1'b1;
              if (cmd_in.cmd.kind == lrc_pkg::CMD_RX_REQ) begin
                emit     = 1'b1;
                e_action = lrc_pkg::ACT_SEND_CONF;
                e_last   = (count_r == '0);
              end
              if (count_r != '0) begin
                state_nxt = S_FLUSH;
              end
            end
            default: begin
              if (restarted_r && (count_r != '0)) begin
                state_nxt = S_FLUSH;
              end
            end
          endcase
        end
      end
      S_REQ: begin
        if (out_free) begin
          emit      = 1'b1;
          e_action  = lrc_pkg::ACT_SEND_REQ;
          state_nxt = S_IDLE;
        end
      end
      S_FLUSH: begin
        if (out_free) begin
          emit      = 1'b1;
          e_action  = lrc_pkg::ACT_SEND_DATA;
          e_handle  = rd_data_r;
          e_last    = (count_r == CNT_W'(1));
          head_nxt  = (head_r == IDX_LAST) ? '0 : head_r + 1'b1;
          count_nxt = count_r - 1'b1;
          if (count_r == CNT_W'(1)) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    out_valid_nxt  = out_valid_r;
    out_action_nxt = out_action_r;
    out_handle_nxt = out_handle_r;
    out_last_nxt   = out_last_r;
    if (emit) begin
      out_valid_nxt  = 1'b1;
      out_action_nxt = e_action;
      out_handle_nxt = e_handle;
      out_last_nxt   = e_last;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      restarted_r <= 1'b0;
      cd_r        <= '0;
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      restarted_r <= restarted_nxt;
      cd_r        <= cd_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_action_r <= out_action_nxt;
    out_handle_r <= out_handle_nxt;
    out_last_r   <= out_last_nxt;
  end

  // read port tracks head_nxt: one handle per cycle unless the output stalls
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[tail_r] <= cmd_in.cmd.handle;
    end
    rd_data_r <= mem[head_nxt];
  end

endmodule
